// ===== hdl/scs_pkg.sv =====
// ============================================================================
// Stepper command sequencer package
// Shared constants, codes and the queue entry type of the stepper command
// sequencer.
// ============================================================================
`default_nettype none

package scs_pkg;

    // Default sizes
    localparam int DEF_QUEUE_DEPTH  = 8;
    localparam int DEF_NUM_STEPPERS = 4;
    localparam int MAX_STEPPERS     = 8;
    localparam int BUSY_BITS        = 4;

    // Period arithmetic
    localparam int          PERIOD_NUMERATOR = 10000;
    localparam int          NUM_W            = $clog2(PERIOD_NUMERATOR + 1);
    localparam logic [15:0] PERIOD_SAT       = 16'hFFFF;

    // Command byte mode codes (high nibble)
    localparam logic [7:0] DIR_REV_CODE = 8'h10;
    localparam logic [7:0] DIR_FWD_CODE = 8'h20;
    localparam logic [7:0] STOP_CODE    = 8'(3 << 4);

    // Item actions
    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_STOP    = 2'd2;

    // Sequencer modes
    localparam logic [2:0] MODE_IDLE        = 3'd0;
    localparam logic [2:0] MODE_SET_CURRENT = 3'd1;
    localparam logic [2:0] MODE_ISSUE       = 3'd2;
    localparam logic [2:0] MODE_CLEAR       = 3'd3;
    localparam logic [2:0] MODE_MONITOR     = 3'd4;
    localparam logic [2:0] MODE_STOP        = 3'd5;

    // One queued stepper command
    typedef struct packed {
        logic [1:0]  motor;
        logic [15:0] speed;
        logic [15:0] steps;
    } fifo_entry_t;

endpackage

`default_nettype wire

// ===== hdl/stepper_command_sequencer.sv =====
// ============================================================================
// Stepper command sequencer
// Queues stepper commands and steps a small command sequencer on each tick,
// issuing command byte, period word and step magnitude registers.
// ============================================================================
//
// Usage:
//   Items enter through start/busy: an item is taken at a clock edge with
//   start high and busy low. Fields action, motor_select, motor_speed,
//   motor_steps and busy_status travel with it.
//   Each item produces one result, shown for a single cycle while done is
//   high. The receiver cannot stall; the result ports hold register values.
//   The drive current register is written over cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high and writes are expected only while idle.
// Sequencing:
//   Enqueue, stop and most ticks pass through the EXEC and DONE states after
//   accept, and busy drops the cycle after done. A tick that issues a command
//   with nonzero speed runs the shared restoring divider in the DIV state,
//   between EXEC and DONE (one quotient bit per cycle). The next item can be
//   taken the cycle after done.
// Reset:
//   rst_n clears the queue pointers and count, the sequencer mode, the
//   monitor mask and all output registers. Queue storage is not cleared;
//   no clearing pass is needed.
//
`default_nettype none

module stepper_command_sequencer
#(
    parameter int QUEUE_DEPTH  = scs_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_STEPPERS = scs_pkg::DEF_NUM_STEPPERS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic [1:0]         motor_select,
    input  wire logic [15:0]        motor_speed,
    input  wire logic signed [15:0] motor_steps,
    input  wire logic [3:0]         busy_status,
    // result channel
    output logic                    done,
    output logic                    accepted,
    output logic [7:0]              command_byte,
    output logic [15:0]             period_word,
    output logic [15:0]             step_count,
    output logic [7:0]              current_value,
    output logic [3:0]              ack_mask,
    output logic                    sequencer_busy,
    // configuration channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data
);

    import scs_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int BITC_W = $clog2(NUM_W);

    // Control sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Control state
    logic [1:0]              state_reg,   state_next;
    logic [2:0]              mode_reg,    mode_next;
    logic [PTR_W-1:0]        wr_ptr_reg,  wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg,  rd_ptr_next;
    logic [CNT_W-1:0]        count_reg,   count_next;
    logic [NUM_STEPPERS-1:0] mask_reg,    mask_next;
    logic [BITC_W-1:0]       bitc_reg,    bitc_next;

    // Output registers
    logic [7:0]              cmd_reg,     cmd_next;
    logic [15:0]             period_reg,  period_next;
    logic [15:0]             steps_reg,   steps_next;
    logic [7:0]              cur_reg,     cur_next;
    logic [7:0]              pwm_reg;
    logic                    acc_reg,     acc_next;
    logic [3:0]              ack_reg,     ack_next;

    // Latched item
    logic [1:0]              act_reg,     act_next;
    fifo_entry_t             item_reg,    item_next;
    logic [3:0]              bsy_reg,     bsy_next;

    // Divider datapath
    logic [15:0]             rem_reg,     rem_next;
    logic [NUM_W-1:0]        quo_reg,     quo_next;
    logic [15:0]             dvs_reg,     dvs_next;

    // Queue storage
    fifo_entry_t             fifo_mem [QUEUE_DEPTH];
    fifo_entry_t             rd_data_reg;
    logic                    fifo_we;

    // Combinational helpers
    logic [16:0]             trial;
    logic [16:0]             diff;
    logic                    ge;
    logic                    do_issue;
    logic                    found;
    logic [MAX_STEPPERS-1:0] mask_ext;
    logic [MAX_STEPPERS-1:0] busy_ext;
    logic [MAX_STEPPERS-1:0] mask_work;

    // Port drive
    assign busy           = (state_reg != ST_IDLE);
    assign done           = (state_reg == ST_DONE);
    assign accepted       = acc_reg;
    assign command_byte   = cmd_reg;
    assign period_word    = period_reg;
    assign step_count     = steps_reg;
    assign current_value  = cur_reg;
    assign ack_mask       = ack_reg;
    assign sequencer_busy = (mode_reg != MODE_IDLE);
    assign cfg_ready      = 1'b1;

    // One restoring divide step
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    // Widen mask and busy bits; busy bits beyond the status field read as idle
    assign mask_ext = MAX_STEPPERS'(mask_reg);
    assign busy_ext = MAX_STEPPERS'(bsy_reg);

    // Next-state logic
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        mask_next   = mask_reg;
        bitc_next   = bitc_reg;
        cmd_next    = cmd_reg;
        period_next = period_reg;
        steps_next  = steps_reg;
        cur_next    = cur_reg;
        acc_next    = acc_reg;
        ack_next    = ack_reg;
        act_next    = act_reg;
        item_next   = item_reg;
        bsy_next    = bsy_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        fifo_we     = 1'b0;
        do_issue    = 1'b0;
        found       = 1'b0;
        mask_work   = mask_ext;

        unique case (state_reg)
            ST_IDLE:
            begin
                // capture the item on transfer
                if (start)
                begin
                    act_next        = action;
                    item_next.motor = motor_select;
                    item_next.speed = motor_speed;
                    item_next.steps = $unsigned(motor_steps);
                    bsy_next        = busy_status;
                    state_next      = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                acc_next   = 1'b0;
                ack_next   = '0;
                state_next = ST_DONE;
                case (act_reg)
                    ACT_ENQUEUE:
                    begin
                        // push unless full
                        if (count_reg < CNT_W'(QUEUE_DEPTH))
                        begin
                            fifo_we     = 1'b1;
                            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                          '0 : wr_ptr_reg + 1'b1;
                            count_next  = count_reg + 1'b1;
                            acc_next    = 1'b1;
                        end
                    end

                    ACT_TICK:
                    begin
                        unique case (mode_reg)
                            MODE_IDLE:
                            begin
                                if (count_reg != '0)
                                    mode_next = MODE_SET_CURRENT;
                            end
                            MODE_SET_CURRENT:
                            begin
                                if (cur_reg == pwm_reg)
                                begin
                                    do_issue  = 1'b1;
                                    mode_next = MODE_CLEAR;
                                end
                                else
                                begin
                                    cur_next  = pwm_reg;
                                    mode_next = MODE_ISSUE;
                                end
                            end
                            MODE_ISSUE:
                            begin
                                do_issue  = 1'b1;
                                mode_next = MODE_CLEAR;
                            end
                            MODE_CLEAR:
                            begin
                                cmd_next  = '0;
                                mode_next = (count_reg != '0) ? MODE_ISSUE : MODE_MONITOR;
                            end
                            MODE_MONITOR:
                            begin
                                // acknowledge steppers whose busy bit dropped
                                if (mask_reg == '0)
                                    mode_next = MODE_IDLE;
                                else
                                begin
                                    ack_next  = 4'(mask_ext & ~busy_ext);
                                    mask_next = NUM_STEPPERS'(mask_ext & busy_ext);
                                end
                            end
                            MODE_STOP:
                            begin
                                // stop the lowest monitored stepper
                                if (mask_reg == '0)
                                    mode_next = MODE_IDLE;
                                else
                                begin
                                    for (int i = 0; i < NUM_STEPPERS; i++)
                                    begin
                                        if (!found && mask_ext[i])
                                        begin
                                            found        = 1'b1;
                                            cmd_next     = 8'(i + 1) + STOP_CODE;
                                            mask_work[i] = 1'b0;
                                        end
                                    end
                                    mask_next = NUM_STEPPERS'(mask_work);
                                end
                            end
                            default:
                            begin
                                mode_next = MODE_IDLE;
                            end
                        endcase

                        // pop the head command and load the registers
                        if (do_issue && count_reg != '0)
                        begin
                            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                          '0 : rd_ptr_reg + 1'b1;
                            count_next  = count_reg - 1'b1;
                            if (rd_data_reg.steps[15])
                            begin
                                steps_next = ~rd_data_reg.steps + 16'd1;
                                cmd_next   = 8'(rd_data_reg.motor) + 8'd1 + DIR_REV_CODE;
                            end
                            else
                            begin
                                steps_next = rd_data_reg.steps;
                                cmd_next   = 8'(rd_data_reg.motor) + 8'd1 + DIR_FWD_CODE;
                            end
                            if (32'(rd_data_reg.motor) < NUM_STEPPERS)
                                mask_next = NUM_STEPPERS'(mask_ext |
                                            (MAX_STEPPERS'(1) << rd_data_reg.motor));
                            if (rd_data_reg.speed == '0)
                                period_next = PERIOD_SAT;
                            else
                            begin
                                rem_next   = '0;
                                quo_next   = NUM_W'(PERIOD_NUMERATOR);
                                dvs_next   = rd_data_reg.speed;
                                bitc_next  = BITC_W'(NUM_W - 1);
                                state_next = ST_DIV;
                            end
                        end
                    end

                    ACT_STOP:
                    begin
                        if (mode_reg != MODE_IDLE)
                            mode_next = MODE_STOP;
                    end

                    default:
                    begin
                    end
                endcase
            end

            ST_DIV:
            begin
                // shift in one quotient bit per cycle
                rem_next  = ge ? diff[15:0] : trial[15:0];
                quo_next  = {quo_reg[NUM_W-2:0], ge};
                bitc_next = bitc_reg - 1'b1;
                if (bitc_reg == '0)
                begin
                    period_next = 16'({quo_reg[NUM_W-2:0], ge});
                    state_next  = ST_DONE;
                end
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            mask_reg   <= '0;
            bitc_reg   <= '0;
            cmd_reg    <= '0;
            period_reg <= '0;
            steps_reg  <= '0;
            cur_reg    <= '0;
            pwm_reg    <= '0;
            acc_reg    <= 1'b0;
            ack_reg    <= '0;
            act_reg    <= ACT_ENQUEUE;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            mask_reg   <= mask_next;
            bitc_reg   <= bitc_next;
            cmd_reg    <= cmd_next;
            period_reg <= period_next;
            steps_reg  <= steps_next;
            cur_reg    <= cur_next;
            acc_reg    <= acc_next;
            ack_reg    <= ack_next;
            act_reg    <= act_next;
            if (cfg_valid && cfg_ready)
                pwm_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        bsy_reg  <= bsy_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
    end

    // Queue memory: write on push, registered read of the head
    always_ff @(posedge clk)
    begin
        if (fifo_we)
            fifo_mem[wr_ptr_reg] <= item_reg;
        rd_data_reg <= fifo_mem[rd_ptr_reg];
    end

`ifndef NO_ASSERTIONS
    // Queue count stays within depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // A taken enqueue only comes from an enqueue item
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted) |-> (act_reg == ACT_ENQUEUE))
        else $error("accepted flag on a non-enqueue item");

    // Acknowledges only come from a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && ack_mask != '0) |-> (act_reg == ACT_TICK))
        else $error("acknowledge on a non-tick item");

    // A transfer makes the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("item transfer did not start work");
`endif

endmodule

`default_nettype wire
